// ----- hw/rtl/adrc_pkg.sv -----
// Shared widths, register map and constants for the drift rate controller.
package adrc_pkg;

   localparam int DELAY_W  = 24;
   localparam int FRAMES_W = 16;
   localparam int TIME_W   = 32;
   localparam int TOTAL_W  = 32;
   localparam int STEP_W   = 8;
   localparam int DEV_W    = DELAY_W + 1;
   localparam int CFG_W    = 16;
   localparam int ADDR_W   = 5;
   localparam int DATA_W   = 32;
   localparam int INDEX_W  = 3;

   localparam logic signed [STEP_W-1:0] MAX_RATE_STEPS = 8'sd100;

   localparam logic ACTION_RESTART = 1'b1;

   localparam logic [INDEX_W-1:0] REG_MIN_TARGET    = 3'd0;
   localparam logic [INDEX_W-1:0] REG_MAX_TARGET    = 3'd1;
   localparam logic [INDEX_W-1:0] REG_TOLERANCE     = 3'd2;
   localparam logic [INDEX_W-1:0] REG_MAX_JUMP      = 3'd3;
   localparam logic [INDEX_W-1:0] REG_UPDATE_PERIOD = 3'd4;
   localparam logic [INDEX_W-1:0] REG_SETTLE_MS     = 3'd5;

   localparam logic [DELAY_W-1:0] RST_MIN_TARGET    = 24'd0;
   localparam logic [DELAY_W-1:0] RST_MAX_TARGET    = 24'hFFFFFF;
   localparam logic [CFG_W-1:0]   RST_TOLERANCE     = 16'd144;
   localparam logic [CFG_W-1:0]   RST_MAX_JUMP      = 16'd480;
   localparam logic [CFG_W-1:0]   RST_UPDATE_PERIOD = 16'd4800;
   localparam logic [CFG_W-1:0]   RST_SETTLE_MS     = 16'd5000;

endpackage

// ----- hw/rtl/adrc_req_if.sv -----
// Update channel: action, frames read, measured delay and timestamp.
interface adrc_req_if;
   import adrc_pkg::*;

   logic                valid;
   logic                ready;
   logic                action;
   logic [FRAMES_W-1:0] frames_used;
   logic [DELAY_W-1:0]  measured_delay;
   logic [TIME_W-1:0]   now_ms;

   modport source (output valid, action, frames_used, measured_delay, now_ms, input ready);
   modport sink   (input valid, action, frames_used, measured_delay, now_ms, output ready);
endinterface

// ----- hw/rtl/adrc_rsp_if.sv -----
// Result channel: change flag, rate step, target delay and active flag.
interface adrc_rsp_if;
   import adrc_pkg::*;

   logic                     valid;
   logic                     ready;
   logic                     ratio_changed;
   logic signed [STEP_W-1:0] rate_step;
   logic [DELAY_W-1:0]       target_delay_out;
   logic                     adaptive_active;

   modport source (output valid, ratio_changed, rate_step, target_delay_out, adaptive_active,
                   input ready);
   modport sink   (input valid, ratio_changed, rate_step, target_delay_out, adaptive_active,
                   output ready);
endinterface

// ----- hw/rtl/audio_drift_rate_controller.sv -----
// Drift rate controller top level.
// Each update is held in the input register, then its result in the result register.
// Throughput: one update per cycle unless the result side stalls; the state
// update sits between the input register and the result register.
// Reset: synchronous; clears all controller state and the valid flags of both
// stages and loads the register defaults.
module audio_drift_rate_controller (
   input  logic                         clock,
   input  logic                         reset,
   adrc_req_if.sink                     req_chan,
   adrc_rsp_if.source                   rsp_chan,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [adrc_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [adrc_pkg::DATA_W-1:0]  csr_pwdata,
   output logic [adrc_pkg::DATA_W-1:0]  csr_prdata,
   output logic                         csr_pready
);
   import adrc_pkg::*;

   localparam logic signed [STEP_W-1:0] NEG_MAX_STEPS = -MAX_RATE_STEPS;

   // configuration
   logic [DELAY_W-1:0] min_target_ff, max_target_ff;
   logic [CFG_W-1:0]   tolerance_ff, max_jump_ff, update_period_ff, settle_ms_ff;
   logic [INDEX_W-1:0] reg_index;
   logic               csr_write;

   // input stage
   logic                in_valid_ff;
   logic                in_action_ff;
   logic [FRAMES_W-1:0] in_frames_ff;
   logic [DELAY_W-1:0]  in_delay_ff;
   logic [TIME_W-1:0]   in_now_ms_ff;

   // result stage
   logic                     rsp_valid_ff;
   logic                     rsp_changed_ff;
   logic signed [STEP_W-1:0] rsp_step_ff;
   logic [DELAY_W-1:0]       rsp_target_ff;
   logic                     rsp_active_ff;

   // controller state
   logic [TOTAL_W-1:0]       frame_total_ff, frame_total_in;
   logic [TOTAL_W-1:0]       last_update_ff, last_update_in;
   logic [DELAY_W-1:0]       target_ff, target_in;
   logic signed [DEV_W-1:0]  prev_dev_ff, prev_dev_in;
   logic signed [STEP_W-1:0] step_ff, step_in;
   logic signed [STEP_W-1:0] steady_ff, steady_in;
   logic [TIME_W-1:0]        reset_time_ff, reset_time_in;
   logic                     settling_ff, settling_in;
   logic                     changed_in;

   logic                    advance;
   logic [TOTAL_W-1:0]      total_sum;
   logic [TOTAL_W-1:0]      since_update;
   logic [TIME_W-1:0]       wait_diff;
   logic signed [DEV_W-1:0] dev;
   logic [DEV_W-1:0]        dev_mag, prev_mag;
   logic [DEV_W-1:0]        tol_ext, jump_ext;

   assign reg_index  = csr_paddr[ADDR_W-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      case (reg_index)
         REG_MIN_TARGET:    csr_prdata = {{(DATA_W-DELAY_W){1'b0}}, min_target_ff};
         REG_MAX_TARGET:    csr_prdata = {{(DATA_W-DELAY_W){1'b0}}, max_target_ff};
         REG_TOLERANCE:     csr_prdata = {{(DATA_W-CFG_W){1'b0}}, tolerance_ff};
         REG_MAX_JUMP:      csr_prdata = {{(DATA_W-CFG_W){1'b0}}, max_jump_ff};
         REG_UPDATE_PERIOD: csr_prdata = {{(DATA_W-CFG_W){1'b0}}, update_period_ff};
         REG_SETTLE_MS:     csr_prdata = {{(DATA_W-CFG_W){1'b0}}, settle_ms_ff};
         default:           csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         min_target_ff    <= RST_MIN_TARGET;
         max_target_ff    <= RST_MAX_TARGET;
         tolerance_ff     <= RST_TOLERANCE;
         max_jump_ff      <= RST_MAX_JUMP;
         update_period_ff <= RST_UPDATE_PERIOD;
         settle_ms_ff     <= RST_SETTLE_MS;
      end else if (csr_write) begin
         case (reg_index)
            REG_MIN_TARGET:    min_target_ff    <= csr_pwdata[DELAY_W-1:0];
            REG_MAX_TARGET:    max_target_ff    <= csr_pwdata[DELAY_W-1:0];
            REG_TOLERANCE:     tolerance_ff     <= csr_pwdata[CFG_W-1:0];
            REG_MAX_JUMP:      max_jump_ff      <= csr_pwdata[CFG_W-1:0];
            REG_UPDATE_PERIOD: update_period_ff <= csr_pwdata[CFG_W-1:0];
            REG_SETTLE_MS:     settle_ms_ff     <= csr_pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   // handshake
   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.ratio_changed    = rsp_changed_ff;
   assign rsp_chan.rate_step        = rsp_step_ff;
   assign rsp_chan.target_delay_out = rsp_target_ff;
   assign rsp_chan.adaptive_active  = rsp_active_ff;

   // datapath terms
   assign total_sum    = frame_total_ff + {{(TOTAL_W-FRAMES_W){1'b0}}, in_frames_ff};
   assign since_update = total_sum - last_update_ff;
   assign wait_diff    = in_now_ms_ff - (reset_time_ff
                         + {{(TIME_W-CFG_W){1'b0}}, settle_ms_ff});
   assign dev          = signed'({1'b0, in_delay_ff}) - signed'({1'b0, target_ff});
   assign dev_mag      = dev[DEV_W-1] ? DEV_W'(-dev) : DEV_W'(dev);
   assign prev_mag     = prev_dev_ff[DEV_W-1] ? DEV_W'(-prev_dev_ff) : DEV_W'(prev_dev_ff);
   assign tol_ext      = {{(DEV_W-CFG_W){1'b0}}, tolerance_ff};
   assign jump_ext     = {{(DEV_W-CFG_W){1'b0}}, max_jump_ff};

   always_comb begin
      frame_total_in = frame_total_ff;
      last_update_in = last_update_ff;
      target_in      = target_ff;
      prev_dev_in    = prev_dev_ff;
      step_in        = step_ff;
      steady_in      = steady_ff;
      reset_time_in  = reset_time_ff;
      settling_in    = settling_ff;
      changed_in     = 1'b0;

      if (in_action_ff == ACTION_RESTART) begin
         step_in       = '0;
         steady_in     = '0;
         target_in     = '0;
         reset_time_in = in_now_ms_ff;
         settling_in   = 1'b1;
         changed_in    = 1'b1;
      end else if (in_frames_ff != '0 &&
                   since_update < {{(TOTAL_W-CFG_W){1'b0}}, update_period_ff}) begin
         // paced out
         frame_total_in = total_sum;
      end else begin
         if (in_frames_ff != '0) begin
            frame_total_in = total_sum;
            last_update_in = total_sum;
         end
         if (dev_mag > jump_ext && !settling_ff) begin
            step_in       = '0;
            steady_in     = '0;
            target_in     = '0;
            reset_time_in = in_now_ms_ff;
            settling_in   = 1'b1;
            changed_in    = 1'b1;
         end else if (target_ff == '0) begin
            if (wait_diff != '0 && !wait_diff[TIME_W-1]) begin
               if (in_delay_ff > max_target_ff) begin
                  target_in  = max_target_ff;
                  step_in    = NEG_MAX_STEPS;
                  changed_in = 1'b1;
               end else if (in_delay_ff < min_target_ff) begin
                  target_in  = min_target_ff;
                  step_in    = MAX_RATE_STEPS;
                  changed_in = 1'b1;
               end else begin
                  target_in   = in_delay_ff;
                  prev_dev_in = '0;
               end
               reset_time_in = '0;
               settling_in   = 1'b0;
            end
         end else begin
            if (dev_mag > tol_ext) begin
               if (!dev[DEV_W-1] && dev != '0 && dev > prev_dev_ff) begin
                  if (step_ff > NEG_MAX_STEPS) begin
                     step_in    = step_ff - 8'sd1;
                     changed_in = 1'b1;
                  end
               end else if (dev[DEV_W-1] && dev < prev_dev_ff) begin
                  if (step_ff < MAX_RATE_STEPS) begin
                     step_in    = step_ff + 8'sd1;
                     changed_in = 1'b1;
                  end
               end
            end else if (prev_mag > tol_ext) begin
               if (!prev_dev_ff[DEV_W-1]) begin
                  if (steady_ff > NEG_MAX_STEPS) begin
                     steady_in  = steady_ff - 8'sd1;
                     step_in    = steady_ff - 8'sd1;
                     changed_in = 1'b1;
                  end
               end else begin
                  if (steady_ff < MAX_RATE_STEPS) begin
                     steady_in  = steady_ff + 8'sd1;
                     step_in    = steady_ff + 8'sd1;
                     changed_in = 1'b1;
                  end
               end
            end
            prev_dev_in = dev;
         end
      end
   end

   // control and state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         frame_total_ff <= '0;
         last_update_ff <= '0;
         target_ff      <= '0;
         prev_dev_ff    <= '0;
         step_ff        <= '0;
         steady_ff      <= '0;
         reset_time_ff  <= '0;
         settling_ff    <= 1'b0;
      end else begin
         if (req_chan.ready) begin
            in_valid_ff <= req_chan.valid;
         end
         if (advance) begin
            rsp_valid_ff   <= 1'b1;
            frame_total_ff <= frame_total_in;
            last_update_ff <= last_update_in;
            target_ff      <= target_in;
            prev_dev_ff    <= prev_dev_in;
            step_ff        <= step_in;
            steady_ff      <= steady_in;
            reset_time_ff  <= reset_time_in;
            settling_ff    <= settling_in;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         in_action_ff <= req_chan.action;
         in_frames_ff <= req_chan.frames_used;
         in_delay_ff  <= req_chan.measured_delay;
         in_now_ms_ff <= req_chan.now_ms;
      end
      if (advance) begin
         rsp_changed_ff <= changed_in;
         rsp_step_ff    <= step_in;
         rsp_target_ff  <= target_in;
         rsp_active_ff  <= (target_in != '0);
      end
   end

endmodule

// ----- tb/adrc_drift_checker.sv -----
// Drift controller checker: tracks register writes, predicts each result and compares.
`timescale 1ns / 100ps

module adrc_drift_checker import adrc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   adrc_req_if               req_mon,
   adrc_rsp_if               rsp_mon,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   input  logic              pready,
   output int                fail_count,
   output int                pending,
   output int                checked,
   output int                captures,
   output int                restarts,
   output int                paced_out,
   output int                rate_changes
);

   localparam int MAX_REPORTS = 100;

   typedef struct packed {
      logic                     ratio_changed;
      logic signed [STEP_W-1:0] rate_step;
      logic [DELAY_W-1:0]       target_out;
      logic                     active;
   } drift_result_type;

   drift_result_type expected_q[$];

   // register copy
   logic [DELAY_W-1:0] cfg_min;
   logic [DELAY_W-1:0] cfg_max;
   logic [CFG_W-1:0]   cfg_tol;
   logic [CFG_W-1:0]   cfg_jump;
   logic [CFG_W-1:0]   cfg_period;
   logic [CFG_W-1:0]   cfg_settle;

   // controller state
   logic [TOTAL_W-1:0]       frames_seen;
   logic [TOTAL_W-1:0]       frames_at_adjust;
   logic [DELAY_W-1:0]       target;
   logic signed [DEV_W-1:0]  last_dev;
   logic signed [STEP_W-1:0] step_cnt;
   logic signed [STEP_W-1:0] steady_cnt;
   logic [TIME_W-1:0]        settle_start_ms;
   logic                     settling;

   task automatic report_failure(input string what);
      if (fail_count < MAX_REPORTS)
         $display("[%0t] CHECK FAILED: %s", $time, what);
      fail_count++;
   endtask

   function automatic void restart_stream(input logic [TIME_W-1:0] now);
      step_cnt        = '0;
      steady_cnt      = '0;
      target          = '0;
      settle_start_ms = now;
      settling        = 1'b1;
      restarts++;
   endfunction

   // returns the ratio_changed flag, updates state in place
   function automatic logic advance_controller(input logic act,
                                               input logic [FRAMES_W-1:0] frames,
                                               input logic [DELAY_W-1:0] delay,
                                               input logic [TIME_W-1:0] now);
      int          dev;
      int          mag;
      int          prev_mag;
      int          tol;
      int          jump;
      logic [31:0] since;
      logic        changed;
      changed = 1'b0;
      if (act == ACTION_RESTART) begin
         restart_stream(now);
         return 1'b1;
      end
      if (frames != '0) begin
         frames_seen = frames_seen + TOTAL_W'(frames);
         if (frames_seen - frames_at_adjust < TOTAL_W'(cfg_period)) begin
            paced_out++;
            return 1'b0;
         end
         frames_at_adjust = frames_seen;
      end
      dev  = int'({8'd0, delay}) - int'({8'd0, target});
      mag  = dev < 0 ? -dev : dev;
      tol  = int'({16'd0, cfg_tol});
      jump = int'({16'd0, cfg_jump});
      if (mag > jump && !settling) begin
         restart_stream(now);
         return 1'b1;
      end
      if (target == '0) begin
         since = now - (settle_start_ms + TIME_W'(cfg_settle));
         if (since != '0 && !since[31]) begin
            if (delay > cfg_max) begin
               target   = cfg_max;
               step_cnt = -MAX_RATE_STEPS;
               changed  = 1'b1;
            end else if (delay < cfg_min) begin
               target   = cfg_min;
               step_cnt = MAX_RATE_STEPS;
               changed  = 1'b1;
            end else begin
               target   = delay;
               last_dev = '0;
            end
            settle_start_ms = '0;
            settling        = 1'b0;
            captures++;
         end
         return changed;
      end
      prev_mag = int'(last_dev) < 0 ? -int'(last_dev) : int'(last_dev);
      if (mag > tol) begin
         if (dev > 0 && dev > last_dev) begin
            if (step_cnt > -MAX_RATE_STEPS) begin
               step_cnt = step_cnt - 8'sd1;
               changed  = 1'b1;
            end
         end else if (dev < 0 && dev < last_dev) begin
            if (step_cnt < MAX_RATE_STEPS) begin
               step_cnt = step_cnt + 8'sd1;
               changed  = 1'b1;
            end
         end
      end else if (prev_mag > tol) begin
         // back inside tolerance: nudge the steady count against the last drift
         if (last_dev > 0) begin
            if (steady_cnt > -MAX_RATE_STEPS) begin
               steady_cnt = steady_cnt - 8'sd1;
               changed    = 1'b1;
            end
         end else begin
            if (steady_cnt < MAX_RATE_STEPS) begin
               steady_cnt = steady_cnt + 8'sd1;
               changed    = 1'b1;
            end
         end
         if (changed)
            step_cnt = steady_cnt;
      end
      last_dev = DEV_W'(dev);
      return changed;
   endfunction

   initial begin
      fail_count   = 0;
      checked      = 0;
      captures     = 0;
      restarts     = 0;
      paced_out    = 0;
      rate_changes = 0;
      pending      = 0;
   end

   always @(posedge clock) begin : monitor
      drift_result_type want;
      drift_result_type got;
      if (reset) begin
         cfg_min          = RST_MIN_TARGET;
         cfg_max          = RST_MAX_TARGET;
         cfg_tol          = RST_TOLERANCE;
         cfg_jump         = RST_MAX_JUMP;
         cfg_period       = RST_UPDATE_PERIOD;
         cfg_settle       = RST_SETTLE_MS;
         frames_seen      = '0;
         frames_at_adjust = '0;
         target           = '0;
         last_dev         = '0;
         step_cnt         = '0;
         steady_cnt       = '0;
         settle_start_ms  = '0;
         settling         = 1'b0;
         expected_q.delete();
         pending <= 0;
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[ADDR_W-1:2])
               REG_MIN_TARGET:    cfg_min    = pwdata[DELAY_W-1:0];
               REG_MAX_TARGET:    cfg_max    = pwdata[DELAY_W-1:0];
               REG_TOLERANCE:     cfg_tol    = pwdata[CFG_W-1:0];
               REG_MAX_JUMP:      cfg_jump   = pwdata[CFG_W-1:0];
               REG_UPDATE_PERIOD: cfg_period = pwdata[CFG_W-1:0];
               REG_SETTLE_MS:     cfg_settle = pwdata[CFG_W-1:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            got.ratio_changed = rsp_mon.ratio_changed;
            got.rate_step     = rsp_mon.rate_step;
            got.target_out    = rsp_mon.target_delay_out;
            got.active        = rsp_mon.adaptive_active;
            if (expected_q.size() == 0) begin
               report_failure("result transfer with no update outstanding");
            end else begin
               want = expected_q.pop_front();
               if (got.ratio_changed !== want.ratio_changed)
                  report_failure($sformatf("result %0d ratio_changed: expected %0b got %0b",
                                           checked, want.ratio_changed, got.ratio_changed));
               if (got.rate_step !== want.rate_step)
                  report_failure($sformatf("result %0d rate_step: expected %0d got %0d",
                                           checked, want.rate_step, got.rate_step));
               if (got.target_out !== want.target_out)
                  report_failure($sformatf("result %0d target_delay_out: expected %0d got %0d",
                                           checked, want.target_out, got.target_out));
               if (got.active !== want.active)
                  report_failure($sformatf("result %0d adaptive_active: expected %0b got %0b",
                                           checked, want.active, got.active));
               checked++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            want.ratio_changed = advance_controller(req_mon.action, req_mon.frames_used,
                                                    req_mon.measured_delay, req_mon.now_ms);
            want.rate_step     = step_cnt;
            want.target_out    = target;
            want.active        = target != '0;
            if (want.ratio_changed)
               rate_changes++;
            expected_q.push_back(want);
         end
         pending <= expected_q.size();
      end
   end

endmodule

// ----- tb/tb_top.sv -----
// Top of the drift controller testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
   import adrc_pkg::*;

   localparam logic ACTION_UPDATE = ~ACTION_RESTART;
   localparam int   PHASES        = 8;
   localparam int   PHASE_ITEMS   = 185;
   localparam int   HOLD_CYCLES   = 300;
   localparam int   DRAIN_LIMIT   = 5000;
   localparam int   DRAIN_CYCLES  = 6;
   localparam int   TIMEOUT_NS    = 1_000_000;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic              pready;

   adrc_req_if req_chan ();
   adrc_rsp_if rsp_chan ();

   int fail_count;
   int pending;
   int checked;
   int captures;
   int restarts;
   int paced_out;
   int rate_changes;

   // stimulus-side copy of the programmed window and timing
   int cfg_lo;
   int cfg_hi;
   int cfg_tol;
   int cfg_jump;
   int cfg_period;
   int cfg_settle;

   int   updates_sent  = 0;
   int   settings_used = 0;
   int   hold_requests = 0;
   logic steady_flow   = 1'b0;

   always #5 clock = ~clock;

   audio_drift_rate_controller DUT (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (psel),
      .csr_penable (penable),
      .csr_pwrite  (pwrite),
      .csr_paddr   (paddr),
      .csr_pwdata  (pwdata),
      .csr_prdata  (prdata),
      .csr_pready  (pready)
   );

   adrc_drift_checker drift_check (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_chan),
      .rsp_mon      (rsp_chan),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .pready       (pready),
      .fail_count   (fail_count),
      .pending      (pending),
      .checked      (checked),
      .captures     (captures),
      .restarts     (restarts),
      .paced_out    (paced_out),
      .rate_changes (rate_changes)
   );

   // result side: random stalls plus long hold-offs on request
   initial begin : result_sink
      int hold_left;
      int holds_seen;
      hold_left  = 0;
      holds_seen = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_seen) begin
            holds_seen = hold_requests;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= steady_flow || $urandom_range(99) >= 7;
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("Timed out with %0d results outstanding", pending);
      $display("Regression FAIL");
      $finish;
   end

   task automatic write_reg(input logic [INDEX_W-1:0] index, input logic [DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_controller(input logic [DELAY_W-1:0] lo, input logic [DELAY_W-1:0] hi,
                                     input logic [CFG_W-1:0] tol, input logic [CFG_W-1:0] jump,
                                     input logic [CFG_W-1:0] period,
                                     input logic [CFG_W-1:0] settle);
      cfg_lo     = lo;
      cfg_hi     = hi;
      cfg_tol    = tol;
      cfg_jump   = jump;
      cfg_period = period;
      cfg_settle = settle;
      write_reg(REG_MIN_TARGET, DATA_W'(lo));
      write_reg(REG_MAX_TARGET, DATA_W'(hi));
      write_reg(REG_TOLERANCE, DATA_W'(tol));
      write_reg(REG_MAX_JUMP, DATA_W'(jump));
      write_reg(REG_UPDATE_PERIOD, DATA_W'(period));
      write_reg(REG_SETTLE_MS, DATA_W'(settle));
      settings_used++;
   endtask

   task automatic drive_update(input logic act, input logic [FRAMES_W-1:0] frames,
                               input logic [DELAY_W-1:0] delay, input logic [TIME_W-1:0] stamp);
      while (!steady_flow && $urandom_range(99) < 7) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid          <= 1'b1;
      req_chan.action         <= act;
      req_chan.frames_used    <= frames;
      req_chan.measured_delay <= delay;
      req_chan.now_ms         <= stamp;
      do @(posedge clock); while (!req_chan.ready);
      updates_sent++;
   endtask

   task automatic drain_results();
      int waited;
      waited = 0;
      do begin
         @(posedge clock);
         waited++;
      end while (pending != 0 && waited < DRAIN_LIMIT);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic int pick_level();
      if ($urandom_range(4) == 0)
         return $urandom_range(24'hFFFFFF, 0);
      return $urandom_range(cfg_lo, cfg_hi);
   endfunction

   function automatic logic [FRAMES_W-1:0] pick_frames();
      int r;
      int p;
      int f;
      r = $urandom_range(99);
      p = cfg_period > 0 ? cfg_period : 1;
      if (r < 15)
         return '0;
      if (r < 25)
         return FRAMES_W'($urandom());
      f = $urandom_range(p * 2, p / 4);
      if (f > 16'hFFFF)
         f = 16'hFFFF;
      return FRAMES_W'(f);
   endfunction

   // a stream of updates: drifting delay around a level, restarts, jumps and noise
   task automatic run_phase(input int n_items, input bit with_hold, input bit with_pause);
      logic [TIME_W-1:0]   now_t;
      logic                act;
      logic [FRAMES_W-1:0] frames;
      logic [DELAY_W-1:0]  delay;
      logic [TIME_W-1:0]   stamp;
      int                  level;
      int                  base;
      int                  r;
      int                  reach;
      int                  stride;
      now_t  = $urandom();
      base   = pick_level();
      level  = base;
      stride = cfg_settle / 6 + 2;
      reach  = cfg_tol + cfg_tol / 2 + 3;
      for (int i = 0; i < n_items; i++) begin
         if (with_hold && i == n_items / 4)
            hold_requests <= hold_requests + 1;
         if (with_pause && i == n_items / 2) begin
            req_chan.valid <= 1'b0;
            do @(posedge clock); while (pending != 0);
         end
         now_t  = now_t + $urandom_range(stride, 0);
         r      = $urandom_range(99);
         act    = ACTION_UPDATE;
         frames = pick_frames();
         if (r < 5) begin
            act    = 1'($urandom());
            frames = FRAMES_W'($urandom());
            delay  = DELAY_W'($urandom());
            stamp  = $urandom();
         end else begin
            if (r < 8) begin
               act   = ACTION_RESTART;
               base  = pick_level();
               level = base;
            end else if (r < 11) begin
               level = level + ($urandom_range(1) ? 1 : -1)
                       * (cfg_jump + int'($urandom_range(cfg_jump + 100, 1)));
            end else if (r < 25) begin
               level = base + int'($urandom_range(cfg_tol, 0)) - cfg_tol / 2;
            end else begin
               level = level + int'($urandom_range(2 * reach, 0)) - reach;
            end
            if (level < 0)
               level = 0;
            if (level > 24'hFFFFFF)
               level = 24'hFFFFFF;
            delay = DELAY_W'(level);
            stamp = now_t;
         end
         drive_update(act, frames, delay, stamp);
      end
      req_chan.valid <= 1'b0;
   endtask

   initial begin : stimulus
      int center;
      int lo;
      int hi;
      int swap;
      int tol;
      int jump;
      req_chan.valid          <= 1'b0;
      req_chan.action         <= ACTION_UPDATE;
      req_chan.frames_used    <= '0;
      req_chan.measured_delay <= '0;
      req_chan.now_ms         <= '0;
      psel                    <= 1'b0;
      penable                 <= 1'b0;
      pwrite                  <= 1'b0;
      paddr                   <= '0;
      pwdata                  <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: settle edge, upper window clamp, stepping, steady nudges, pacing, jumps
      program_controller(24'd1000, 24'd50000, 16'd10, 16'd200, 16'd100, 16'd50);
      drive_update(ACTION_RESTART, 16'd0, 24'd0, 32'd1000);
      drive_update(ACTION_UPDATE, 16'd0, 24'd5000, 32'd1050);
      drive_update(ACTION_UPDATE, 16'd0, 24'd60000, 32'd1051);
      drive_update(ACTION_UPDATE, 16'd0, 24'd50005, 32'd1052);
      drive_update(ACTION_UPDATE, 16'd0, 24'd49970, 32'd1053);
      drive_update(ACTION_UPDATE, 16'd0, 24'd49960, 32'd1054);
      drive_update(ACTION_UPDATE, 16'd0, 24'd50000, 32'd1055);
      drive_update(ACTION_UPDATE, 16'd0, 24'd50050, 32'd1056);
      drive_update(ACTION_UPDATE, 16'd0, 24'd50000, 32'd1057);
      drive_update(ACTION_UPDATE, 16'd60, 24'd50000, 32'd1058);
      drive_update(ACTION_UPDATE, 16'd50, 24'd50500, 32'd1060);
      drive_update(ACTION_UPDATE, 16'd0, 24'd500, 32'd1111);
      drive_update(ACTION_RESTART, 16'hFFFF, 24'hFFFFFF, 32'hFFFF_FFC0);
      req_chan.valid <= 1'b0;
      drain_results();

      // directed: timestamp wrap, zero target, full-scale delay
      program_controller(24'd0, 24'hFFFFFF, 16'd10, 16'd200, 16'd100, 16'd50);
      drive_update(ACTION_UPDATE, 16'hFFFF, 24'd0, 32'd0);
      drive_update(ACTION_UPDATE, 16'd0, 24'd0, 32'hFFFF_FFFF);
      drive_update(ACTION_UPDATE, 16'd0, 24'd150, 32'd1000);
      drive_update(ACTION_UPDATE, 16'd0, 24'hFFFFFF, 32'd1001);
      drive_update(ACTION_UPDATE, 16'd0, 24'hFFFFFF, 32'd1052);
      drive_update(ACTION_UPDATE, 16'd0, 24'hFFFF9B, 32'd1053);
      drive_update(ACTION_UPDATE, 16'hFFFF, 24'hFFFFFF, 32'd1054);
      req_chan.valid <= 1'b0;
      drain_results();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: program_controller(RST_MIN_TARGET, RST_MAX_TARGET, RST_TOLERANCE, RST_MAX_JUMP,
                                  RST_UPDATE_PERIOD, RST_SETTLE_MS);
            1: program_controller('0, '0, '0, '0, '0, '0);
            2: program_controller('1, '1, '1, '1, '1, '1);
            default: begin
               center = $urandom_range(24'hFFFFFF, 0);
               lo     = center - int'($urandom_range(20000, 0));
               hi     = center + int'($urandom_range(20000, 0));
               if (lo < 0)
                  lo = 0;
               if (hi > 24'hFFFFFF)
                  hi = 24'hFFFFFF;
               if ($urandom_range(5) == 0) begin
                  swap = lo;
                  lo   = hi;
                  hi   = swap;
               end
               tol  = $urandom_range(300, 0);
               jump = ($urandom_range(5) == 0) ? $urandom_range(300, 0)
                                               : tol + int'($urandom_range(1500, 0));
               program_controller(DELAY_W'(lo), DELAY_W'(hi), CFG_W'(tol), CFG_W'(jump),
                                  CFG_W'($urandom_range(3000, 0)),
                                  CFG_W'($urandom_range(2000, 0)));
            end
         endcase
         steady_flow <= (p == 4);
         run_phase(PHASE_ITEMS, p == 3 || p == 6, p == 5);
         drain_results();
      end

      $display("Sent %0d updates under %0d register settings; %0d results checked.",
               updates_sent, settings_used, checked);
      $display("Saw %0d target captures, %0d restarts, %0d paced-out updates, %0d rate changes.",
               captures, restarts, paced_out, rate_changes);
      if (pending != 0)
         $display("%0d expected results never arrived", pending);
      if (fail_count == 0 && pending == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/adrc_pkg.sv
hw/rtl/adrc_req_if.sv
hw/rtl/adrc_rsp_if.sv
hw/rtl/audio_drift_rate_controller.sv
tb/adrc_drift_checker.sv
tb/tb_top.sv
